// ===== src/aat_pkg.sv =====
`timescale 1ns / 1ps

package aat_pkg;

    localparam int ENTRIES_DEF    = 8;
    localparam int ADDR_BYTES_DEF = 6;
    localparam int FIELD_W        = 48;
    localparam int WIDE_W         = 64;
    localparam int AGE_W          = 8;
    localparam int IDX_W          = 6;
    localparam int SLOT_W         = 3;
    localparam int OUTC_W         = 3;
    localparam int CFG_W          = 8;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_AGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT     = 1'd1;

    localparam logic [CFG_W-1:0] TICKS_PER_AGE_RST = 8'd60;
    localparam logic [CFG_W-1:0] AGE_LIMIT_RST     = 8'd255;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [OUTC_W-1:0] OUT_HIT     = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_FILL    = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_REPLACE = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_COUNT   = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_AGED    = 3'd4;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] address;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [OUTC_W-1:0]  outcome;
        logic [FIELD_W-1:0] evicted_address;
    } t_out_beat;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_vld;
        logic [IDX_W-1:0] free_idx;
        logic             best_vld;
        logic [AGE_W-1:0] best_age;
        logic [IDX_W-1:0] best_idx;
    } t_scan;

    typedef struct packed {
        logic             load;
        logic             age_step;
        logic [AGE_W-1:0] age_limit;
    } t_cmd;

endpackage

// ===== src/aging_address_table.sv =====
`timescale 1ns / 1ps

// Aging address table: a row of ENTRIES cells holding address, valid mark and age.
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat per item, either
// an add of an address or a timer tick. One item is worked on at a time; o_in_stall
// stays high from acceptance until that item's result has been loaded for output.
// An add sweeps a search record through the cells, one cell per cycle, then commits
// the chosen entry once the output register is free: the cell and the result
// register load together, and the next beat is taken after that commit.
// A tick needs no sweep: it commits as soon as the output register is free.
// Output channel (o_out_valid / i_out_stall / o_out_data): a register holds the
// result; while the receiver stalls it holds, and a finished item waits to commit.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data): index 0 ticks_per_age,
// index 1 age_limit; write only while the block is idle.
// Reset (synchronous, active low) clears all valid marks, the tick prescaler and
// the output valid flag, and restores the register defaults. No clearing pass.
module aging_address_table #(
    parameter int ENTRIES    = aat_pkg::ENTRIES_DEF,
    parameter int ADDR_BYTES = aat_pkg::ADDR_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  aat_pkg::t_in_beat               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output aat_pkg::t_out_beat              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aat_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int AW = 8 * ADDR_BYTES;

    logic                          r_busy;
    logic                          r_is_tick;
    logic                          r_start;
    logic                          r_done;
    logic [AW-1:0]                 r_key;
    logic [aat_pkg::CFG_W-1:0]     r_tick_cnt;
    logic [aat_pkg::CFG_W-1:0]     r_ticks_per_age;
    logic [aat_pkg::AGE_W-1:0]     r_age_limit;
    logic                          r_out_vld;
    aat_pkg::t_out_beat            r_out;

    aat_pkg::t_out_beat            n_out;
    logic [aat_pkg::IDX_W-1:0]     n_sel_idx;
    logic                          w_accept;
    logic                          w_commit;
    logic [aat_pkg::CFG_W:0]       w_tick_next;
    logic                          w_aging;
    logic [aat_pkg::WIDE_W-1:0]    w_in_wide;
    logic [aat_pkg::WIDE_W-1:0]    w_ev_wide;
    aat_pkg::t_cmd                 w_cmd;
    aat_pkg::t_scan                w_final;

    logic                          w_go        [ENTRIES+1];
    aat_pkg::t_scan                w_scan      [ENTRIES+1];
    logic [AW-1:0]                 w_best_addr [ENTRIES+1];
    logic [ENTRIES-1:0]            w_sel;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_commit    = r_busy && (r_is_tick || r_done) && (!r_out_vld || !i_out_stall);
    assign w_tick_next = {1'b0, r_tick_cnt} + 1'b1;
    assign w_aging     = w_tick_next >= {1'b0, r_ticks_per_age};
    assign w_in_wide   = aat_pkg::WIDE_W'(i_in_data.address);
    assign w_final     = w_scan[ENTRIES];
    assign w_ev_wide   = aat_pkg::WIDE_W'(w_best_addr[ENTRIES]);

    assign w_go[0]        = r_start;
    assign w_scan[0]      = '0;
    assign w_best_addr[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            assign w_sel[g] = (n_sel_idx == aat_pkg::IDX_W'(g));
            aat_cell #(
                .AW(AW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_idx       (aat_pkg::IDX_W'(g)),
                .i_key       (r_key),
                .i_go        (w_go[g]),
                .i_scan      (w_scan[g]),
                .i_best_addr (w_best_addr[g]),
                .i_sel       (w_sel[g]),
                .i_cmd       (w_cmd),
                .o_go        (w_go[g+1]),
                .o_scan      (w_scan[g+1]),
                .o_best_addr (w_best_addr[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_out     = '0;
        n_sel_idx = w_final.best_idx;
        if (r_is_tick) begin
            n_out.outcome = w_aging ? aat_pkg::OUT_AGED : aat_pkg::OUT_COUNT;
        end else if (w_final.hit) begin
            n_sel_idx     = w_final.hit_idx;
            n_out.outcome = aat_pkg::OUT_HIT;
        end else if (w_final.free_vld) begin
            n_sel_idx     = w_final.free_idx;
            n_out.outcome = aat_pkg::OUT_FILL;
        end else begin
            n_out.outcome         = aat_pkg::OUT_REPLACE;
            n_out.evicted_address = w_ev_wide[aat_pkg::FIELD_W-1:0];
        end
        if (!r_is_tick) begin
            n_out.slot = n_sel_idx[aat_pkg::SLOT_W-1:0];
        end
    end

    always_comb begin
        w_cmd.load      = w_commit && !r_is_tick;
        w_cmd.age_step  = w_commit && r_is_tick && w_aging;
        w_cmd.age_limit = r_age_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_start         <= 1'b0;
            r_done          <= 1'b0;
            r_tick_cnt      <= '0;
            r_ticks_per_age <= aat_pkg::TICKS_PER_AGE_RST;
            r_age_limit     <= aat_pkg::AGE_LIMIT_RST;
            r_out_vld       <= 1'b0;
        end else begin
            r_start <= w_accept && (i_in_data.action == aat_pkg::ACT_ADD);
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_go[ENTRIES]) begin
                r_done <= 1'b1;
            end else if (w_commit) begin
                r_done <= 1'b0;
            end
            if (w_commit && r_is_tick) begin
                r_tick_cnt <= w_aging ? '0 : w_tick_next[aat_pkg::CFG_W-1:0];
            end
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aat_pkg::REG_TICKS_PER_AGE: r_ticks_per_age <= i_cfg_data;
                    aat_pkg::REG_AGE_LIMIT:     r_age_limit     <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_tick <= (i_in_data.action == aat_pkg::ACT_TICK);
            r_key     <= w_in_wide[AW-1:0];
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== src/aat_cell.sv =====
`timescale 1ns / 1ps

module aat_cell #(
    parameter int AW = 8 * aat_pkg::ADDR_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [aat_pkg::IDX_W-1:0]    i_idx,
    input  logic [AW-1:0]                i_key,
    input  logic                         i_go,
    input  aat_pkg::t_scan               i_scan,
    input  logic [AW-1:0]                i_best_addr,
    input  logic                         i_sel,
    input  aat_pkg::t_cmd                i_cmd,
    output logic                         o_go,
    output aat_pkg::t_scan               o_scan,
    output logic [AW-1:0]                o_best_addr
);

    logic                         r_valid;
    logic [AW-1:0]                r_addr;
    logic [aat_pkg::AGE_W-1:0]    r_age;
    logic                         r_go;
    aat_pkg::t_scan               r_scan;
    logic [AW-1:0]                r_best_addr;
    aat_pkg::t_scan               n_scan;
    logic [AW-1:0]                n_best_addr;

    always_comb begin
        n_scan      = i_scan;
        n_best_addr = i_best_addr;
        if (!i_scan.hit) begin
            if (!r_valid) begin
                n_scan.free_vld = 1'b1;
                n_scan.free_idx = i_idx;
            end else if (r_addr == i_key) begin
                n_scan.hit     = 1'b1;
                n_scan.hit_idx = i_idx;
            end else if (!i_scan.best_vld || (r_age > i_scan.best_age)) begin
                n_scan.best_vld = 1'b1;
                n_scan.best_age = r_age;
                n_scan.best_idx = i_idx;
                n_best_addr     = r_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_go <= i_go;
            if (i_cmd.load && i_sel) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_scan      <= n_scan;
            r_best_addr <= n_best_addr;
        end
        if (i_cmd.load && i_sel) begin
            r_addr <= i_key;
            r_age  <= '0;
        end else if (i_cmd.age_step && r_valid && (r_age < i_cmd.age_limit)) begin
            r_age <= r_age + 1'b1;
        end
    end

    assign o_go        = r_go;
    assign o_scan      = r_scan;
    assign o_best_addr = r_best_addr;

endmodule

// ===== src/aat_checker.sv =====
`timescale 1ns / 1ps

module aat_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input aat_pkg::t_out_beat  o_out_data
);

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat accepted while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

    a_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.outcome == aat_pkg::OUT_HIT
            || o_out_data.outcome == aat_pkg::OUT_FILL
            || o_out_data.outcome == aat_pkg::OUT_REPLACE
            || o_out_data.outcome == aat_pkg::OUT_COUNT
            || o_out_data.outcome == aat_pkg::OUT_AGED))
        else $error("outcome code out of range");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.outcome != aat_pkg::OUT_REPLACE)
            |-> (o_out_data.evicted_address == '0))
        else $error("evicted address without replacement");

    a_tick_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.outcome == aat_pkg::OUT_COUNT
            || o_out_data.outcome == aat_pkg::OUT_AGED)) |-> (o_out_data.slot == '0))
        else $error("tick result carries a slot");

endmodule

bind aging_address_table aat_checker u_aat_checker (.*);
